FILE: rtl/depth_pixel_unproject_defines.svh
// Assertion macros for the depth pixel unprojection block.
`ifndef DEPTH_PIXEL_UNPROJECT_DEFINES_SVH
`define DEPTH_PIXEL_UNPROJECT_DEFINES_SVH
`ifndef ASSERT_OFF
`define DPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DPU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPU_ASSERT(lbl, prop, msg)
`define DPU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/dpu_pkg.sv
// Shared constants and types of the depth pixel unprojection block.
package dpu_pkg;
  localparam int COL_W          = 12;
  localparam int DEPTH_W        = 24;
  localparam int COEF_W         = 32;
  localparam int OUT_W          = 48;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 64;
  localparam int NUM_REGS       = 8;
  localparam int PIX_BITS_DEF   = 12;
  localparam int DEPTH_BITS_DEF = 24;
  localparam int QUOT_STEPS     = 48;
  localparam int INT_SHIFT      = 31;
  localparam int FRAC_BITS      = 17;
  localparam logic [OUT_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

  typedef struct packed {
    logic vld;
    logic blank;
  } dpu_ctl_t;
endpackage

FILE: rtl/dpu_in_if.sv
// Pixel input channel.
interface dpu_in_if import dpu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   pixel_col;
  logic [COL_W-1:0]   pixel_row;
  logic [DEPTH_W-1:0] depth_code;
  modport source (output valid, pixel_col, pixel_row, depth_code, input ready);
  modport sink   (input valid, pixel_col, pixel_row, depth_code, output ready);
endinterface

FILE: rtl/dpu_out_if.sv
// World point result channel.
interface dpu_out_if import dpu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;
  logic signed [OUT_W-1:0] point_z;
  logic                    point_valid;
  modport source (output valid, point_x, point_y, point_z, point_valid, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_valid, output ready);
endinterface

FILE: rtl/dpu_cfg_if.sv
// Coefficient register write channel.
interface dpu_cfg_if import dpu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/dpu_matrix.sv
// Three-stage 4x4 matrix times (col, row, depth, 1) pipeline.
module dpu_matrix import dpu_pkg::*; #(
  parameter int CW         = PIX_BITS_DEF,
  parameter int DW         = DEPTH_BITS_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF,
  parameter int ACC_W      = 34 + PIX_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  logic [CW-1:0]                         col,
  input  logic [CW-1:0]                         row,
  input  logic [DW-1:0]                         code,
  input  logic [3:0][3:0][COEF_W-1:0]           coef,
  output dpu_ctl_t                              ctl,
  output logic [3:0][ACC_W-1:0]                 acc
);
  localparam int PW = COEF_W + CW + 1;
  localparam int DPW = COEF_W + DW + 1;
  localparam longint unsigned DMAX = (64'd1 << DEPTH_BITS) - 64'd1;
  localparam longint unsigned BG_CODE = DMAX - (DMAX - 64'd1) / 64'd1000000;

  dpu_ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic signed [PW-1:0]     pc_r [4];
  logic signed [PW-1:0]     pr_r [4];
  logic signed [DPW-1:0]    pd_r [4];
  logic signed [COEF_W-1:0] c3_r [4];
  logic signed [ACC_W-1:0]  sa_r [4];
  logic signed [ACC_W-1:0]  sb_r [4];
  logic signed [ACC_W-1:0]  acc_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r.vld   <= in_vld;
      ctl1_r.blank <= (64'(code) >= BG_CODE);
      ctl2_r       <= ctl1_r;
      ctl3_r       <= ctl2_r;
    end
  end

  // products, then pair sums, then the final sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pc_r[k]  <= $signed(coef[k][0]) * $signed({1'b0, col});
        pr_r[k]  <= $signed(coef[k][1]) * $signed({1'b0, row});
        pd_r[k]  <= $signed(coef[k][2]) * $signed({1'b0, code});
        c3_r[k]  <= $signed(coef[k][3]);
        sa_r[k]  <= ACC_W'(pc_r[k]) + ACC_W'(pr_r[k]);
        sb_r[k]  <= ACC_W'(pd_r[k] >>> DEPTH_BITS) + ACC_W'(c3_r[k]);
        acc_r[k] <= sa_r[k] + sb_r[k];
      end
    end
  end

  assign ctl = ctl3_r;
  always_comb begin
    for (int k = 0; k < 4; k++) acc[k] = acc_r[k];
  end
endmodule

FILE: rtl/dpu_divider.sv
// Pipelined signed divide by w with rounding and saturation, three lanes.
module dpu_divider import dpu_pkg::*; #(
  parameter int ACC_W = 34 + PIX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  dpu_ctl_t                     in_ctl,
  input  logic [3:0][ACC_W-1:0]        acc,
  output logic                         out_vld,
  output logic [2:0][OUT_W-1:0]        res,
  output logic                         res_ok
);
  localparam int S = QUOT_STEPS;

  dpu_ctl_t          ctla_r, ctlc_r, ctlo_r;
  logic [2:0]        nega_r, negc_r;
  logic [ACC_W-1:0]  mna_r [3];
  logic [ACC_W-1:0]  mda_r;
  logic [2:0]        satc_r;
  logic [OUT_W-1:0]  mc_r [3];
  logic [2:0][OUT_W-1:0] res_r;

  dpu_ctl_t          ctl_r [S+1];
  logic [ACC_W-1:0]  md_r  [S+1];
  logic [2:0]        neg_r [S+1];
  logic [2:0]        sat_r [S+1];
  logic [ACC_W-1:0]  p_r   [S+1][3];
  logic [OUT_W-1:0]  sh_r  [S+1][3];

  // stage A: sign and magnitude, zero w
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctla_r <= '0;
    end else if (en) begin
      ctla_r.vld   <= in_ctl.vld;
      ctla_r.blank <= in_ctl.blank || (acc[3] == '0);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        nega_r[l] <= acc[l][ACC_W-1] ^ acc[3][ACC_W-1];
        mna_r[l]  <= acc[l][ACC_W-1] ? (~acc[l] + 1'b1) : acc[l];
      end
      mda_r <= acc[3][ACC_W-1] ? (~acc[3] + 1'b1) : acc[3];
    end
  end

  // stage B: overflow check, seed the partial remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctla_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0]  <= mda_r;
      neg_r[0] <= nega_r;
      for (int l = 0; l < 3; l++) begin
        sat_r[0][l] <= (mna_r[l] >> INT_SHIFT) >= mda_r;
        p_r[0][l]   <= mna_r[l] >> INT_SHIFT;
        sh_r[0][l]  <= {mna_r[l][INT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      end
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < S; s++) begin : g_step
    logic [ACC_W:0] t_w  [3];
    logic [2:0]     ge_w;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      assign t_w[l]  = {p_r[s][l], sh_r[s][l][OUT_W-1]};
      assign ge_w[l] = t_w[l] >= {1'b0, md_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1] <= '0;
      end else if (en) begin
        ctl_r[s+1] <= ctl_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        md_r[s+1]  <= md_r[s];
        neg_r[s+1] <= neg_r[s];
        sat_r[s+1] <= sat_r[s];
        for (int l = 0; l < 3; l++) begin
          p_r[s+1][l]  <= ge_w[l] ? ACC_W'(t_w[l] - {1'b0, md_r[s]}) : ACC_W'(t_w[l]);
          sh_r[s+1][l] <= {sh_r[s][l][OUT_W-2:0], ge_w[l]};
        end
      end
    end
  end

  // stage C: round half away, clamp the positive side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlc_r <= '0;
      ctlo_r <= '0;
    end else if (en) begin
      ctlc_r <= ctl_r[S];
      ctlo_r <= ctlc_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      negc_r <= neg_r[S];
      satc_r <= sat_r[S];
      for (int l = 0; l < 3; l++) begin
        if (!neg_r[S][l] &&
            ((({1'b0, sh_r[S][l]} + 1'b1) >> 1) > {1'b0, POS_LIMIT})) begin
          mc_r[l] <= POS_LIMIT;
        end else begin
          mc_r[l] <= OUT_W'(({1'b0, sh_r[S][l]} + 1'b1) >> 1);
        end
      end
      // output: blank, saturated or signed quotient
      for (int l = 0; l < 3; l++) begin
        if (ctlc_r.blank) begin
          res_r[l] <= '1;
        end else if (satc_r[l]) begin
          res_r[l] <= negc_r[l] ? NEG_LIMIT : POS_LIMIT;
        end else begin
          res_r[l] <= negc_r[l] ? (~mc_r[l] + 1'b1) : mc_r[l];
        end
      end
    end
  end

  assign out_vld = ctlo_r.vld;
  assign res_ok  = !ctlo_r.blank;
  assign res     = res_r;
endmodule

FILE: rtl/depth_pixel_unproject.sv
// Top level of the depth pixel unprojection block.
//
//  channel   dir  payload                                  beat when
//  in_ch     in   pixel_col, pixel_row, depth_code         valid & ready
//  out_ch    out  point_x, point_y, point_z, point_valid   valid & ready
//  cfg_ch    in   index (8b), data (64b)                   valid & ready
//
// Throughput is one pixel beat per clock while the output is not stalled; the pipeline
// has three matrix stages, two divide setup stages, one stage per quotient bit (48) and
// two rounding/output stages. The quotient-bit stages of the divider set the depth.
// rst_n (synchronous) clears all valid bits and the coefficient registers.
// A stalled output beat holds the whole pipeline in place; nothing is lost.
`include "depth_pixel_unproject_defines.svh"
module depth_pixel_unproject import dpu_pkg::*; #(
  parameter int PIXEL_INDEX_BITS = PIX_BITS_DEF,
  parameter int DEPTH_BITS       = DEPTH_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  dpu_in_if.sink     in_ch,
  dpu_out_if.source  out_ch,
  dpu_cfg_if.sink    cfg_ch
);
  // usable input bits and accumulator width (col and row terms dominate)
  localparam int CW    = (PIXEL_INDEX_BITS < COL_W) ? PIXEL_INDEX_BITS : COL_W;
  localparam int DW    = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;
  localparam int ACC_W = 34 + CW;

  logic [3:0][3:0][COEF_W-1:0] coef_r;
  logic                        adv;
  dpu_ctl_t                    mat_ctl;
  logic [3:0][ACC_W-1:0]       mat_acc;
  logic [2:0][OUT_W-1:0]       res;
  logic                        res_ok;
  logic                        res_vld;

  // advance when the output register is empty or its beat is taken
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign cfg_ch.ready = 1'b1;

  // coefficient writes: drop indexes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_ch.valid && (cfg_ch.index < CFG_IDX_W'(NUM_REGS))) begin
      coef_r[cfg_ch.index[2:1]][{cfg_ch.index[0], 1'b0}] <= cfg_ch.data[31:0];
      coef_r[cfg_ch.index[2:1]][{cfg_ch.index[0], 1'b1}] <= cfg_ch.data[63:32];
    end
  end

  dpu_matrix #(
    .CW(CW), .DW(DW), .DEPTH_BITS(DEPTH_BITS), .ACC_W(ACC_W)
  ) u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_ch.valid),
    .col    (in_ch.pixel_col[CW-1:0]),
    .row    (in_ch.pixel_row[CW-1:0]),
    .code   (in_ch.depth_code[DW-1:0]),
    .coef   (coef_r),
    .ctl    (mat_ctl),
    .acc    (mat_acc)
  );

  dpu_divider #(.ACC_W(ACC_W)) u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_ctl  (mat_ctl),
    .acc     (mat_acc),
    .out_vld (res_vld),
    .res     (res),
    .res_ok  (res_ok)
  );

  assign out_ch.valid       = res_vld;
  assign out_ch.point_x     = res[0];
  assign out_ch.point_y     = res[1];
  assign out_ch.point_z     = res[2];
  assign out_ch.point_valid = res_ok;

  `DPU_ASSERT(a_stall_blocks_in, (out_ch.valid && !out_ch.ready) |-> !in_ch.ready, "input taken during output stall")
  `DPU_ASSERT(a_blank_all_ones, (out_ch.valid && !out_ch.point_valid) |-> (out_ch.point_x == '1 && out_ch.point_y == '1 && out_ch.point_z == '1), "blank point not all ones")
  `DPU_ASSERT_RST(a_reset_empty, !rst_n |=> !out_ch.valid, "output valid right after reset")
endmodule

FILE: tb/depth_pixel_unproject_tb.sv
// Self-checking testbench for the depth pixel unprojection block.
module depth_pixel_unproject_tb;
  import dpu_pkg::*;

  localparam int            PERIOD     = 20;
  localparam int            DRAIN_WAIT = 70;    // a little past the pipeline depth
  localparam int            STALL_MAX  = 3000;  // cycles with no beat anywhere
  localparam int            NUM_PHASES = 6;
  localparam int            PHASE_PIX  = 230;
  localparam int            BAD_INDEX  = 9;     // unmapped register, must be ignored
  localparam logic [31:0]   ONE_Q16    = 32'h0001_0000;
  localparam logic [31:0]   MAX_Q16    = 32'h7FFF_FFFF;
  localparam logic [31:0]   MIN_Q16    = 32'h8000_0000;
  localparam logic [47:0]   ALL_ONES   = '1;
  localparam logic [23:0]   DEPTH_MAX  = '1;

  typedef struct {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             v;
  } point_t;

  // Holds its own copy of the matrix and the points still owed by the block.
  class point_scoreboard;
    longint        coef[4][4];
    point_t        owed_points[$];
    int            mismatches;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int r, h;
      if (idx >= NUM_REGS) return;
      r = idx >> 1;
      h = idx & 1;
      coef[r][2*h]   = longint'($signed(data[31:0]));
      coef[r][2*h+1] = longint'($signed(data[63:32]));
    endfunction

    function logic [OUT_W-1:0] divide_q16(longint num, longint den);
      bit                neg;
      longint unsigned   mn, md, q, r, f, m;
      neg = (num < 0) != (den < 0);
      mn  = (num < 0) ? -num : num;
      md  = (den < 0) ? -den : den;
      q   = mn / md;
      r   = mn % md;
      f   = 0;
      if (q >= 64'h8000_0000) begin
        m = neg ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
      end else begin
        for (int i = 0; i < FRAC_BITS; i++) begin
          r = r << 1;
          f = f << 1;
          if (r >= md) begin
            r = r - md;
            f = f | 1;
          end
        end
        m = (((q << FRAC_BITS) | f) + 1) >> 1;
        if (!neg && m > 64'(POS_LIMIT)) m = 64'(POS_LIMIT);
      end
      return neg ? OUT_W'(-m) : OUT_W'(m);
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row, logic [23:0] depth);
      point_t  p;
      longint  acc[4];
      longint  dterm;
      if (64'(DEPTH_MAX - depth) * 1000000 < 64'(DEPTH_MAX)) begin
        p = '{ALL_ONES, ALL_ONES, ALL_ONES, 1'b0};
      end else begin
        for (int k = 0; k < 4; k++) begin
          dterm  = (coef[k][2] * longint'(depth)) >>> DEPTH_W;
          acc[k] = coef[k][0] * longint'(col) + coef[k][1] * longint'(row)
                   + dterm + coef[k][3];
        end
        if (acc[3] == 0)
          p = '{ALL_ONES, ALL_ONES, ALL_ONES, 1'b0};
        else
          p = '{divide_q16(acc[0], acc[3]), divide_q16(acc[1], acc[3]),
                divide_q16(acc[2], acc[3]), 1'b1};
      end
      owed_points.push_back(p);
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (owed_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%h y=%h z=%h v=%b", got.x, got.y, got.z, got.v);
        return;
      end
      want = owed_points.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z || got.v !== want.v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("point mismatch: want x=%h y=%h z=%h v=%b, got x=%h y=%h z=%h v=%b",
                   want.x, want.y, want.z, want.v, got.x, got.y, got.z, got.v);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;        // when set, neither side idles
  int   stall_cycles;

  dpu_in_if  in_ch();
  dpu_out_if out_ch();
  dpu_cfg_if cfg_ch();

  point_scoreboard sb = new();

  depth_pixel_unproject u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0; #(PERIOD/2);
    clk = 1'b1; #(PERIOD/2);
  end

  // Sample every beat at the rising edge; feed the model and the checker.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        sb.note_pixel(in_ch.pixel_col, in_ch.pixel_row, in_ch.depth_code);
      if (out_ch.valid && out_ch.ready)
        sb.check_point('{out_ch.point_x, out_ch.point_y, out_ch.point_z, out_ch.point_valid});
      // Watchdog: count cycles with no beat on any channel.
      if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready)
          || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side back-pressure: stall about 6 beats in 100 unless quiet.
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 6);
  end

  // Drive one register write; hold valid until the beat is taken.
  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Drive one pixel beat, after an occasional idle gap.
  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [23:0] depth);
    while (!quiet && $urandom_range(99) < 6) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.pixel_col  = col;
    in_ch.pixel_row  = row;
    in_ch.depth_code = depth;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed point is back, then let the pipe settle.
  task automatic drain();
    in_ch.valid  = 1'b0;
    cfg_ch.valid = 1'b0;
    while (sb.owed_points.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coef(int mode);
    case (mode)
      0: return $urandom();
      1: return MAX_Q16;
      2: return MIN_Q16;
      3: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      4: return ONE_Q16;
      default: return '0;
    endcase
  endfunction

  // Load all eight registers for a phase.
  task automatic load_matrix(int phase);
    logic [31:0] c[4][4];
    for (int r = 0; r < 4; r++)
      for (int k = 0; k < 4; k++)
        case (phase)
          1: c[r][k] = (r == k || (r == 3 && k == 3)) ? ONE_Q16 : '0;
          2: c[r][k] = $urandom_range(1) ? MAX_Q16 : MIN_Q16;
          3: c[r][k] = pick_coef($urandom_range(0, 5));
          default: c[r][k] = (r == 3) ? pick_coef($urandom_range(3, 5)) : pick_coef(3);
        endcase
    // Keep w clear of zero in the identity phase; small w in phases 4 and 5 drives saturation.
    for (int r = 0; r < 4; r++) begin
      write_coef(2*r,   {c[r][1], c[r][0]});
      write_coef(2*r+1, {c[r][3], c[r][2]});
    end
    write_coef(BAD_INDEX, {$urandom(), $urandom()});
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [23:0] pick_depth();
    case ($urandom_range(0, 9))
      0:       return DEPTH_MAX - 24'($urandom_range(0, 20));
      1:       return 24'($urandom_range(0, 15));
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    logic [11:0] edge_val[2];
    logic [23:0] depth_set[6];
    rst_n         = 1'b0;
    quiet         = 1'b0;
    stall_cycles  = 0;
    in_ch.valid   = 1'b0;
    in_ch.pixel_col  = '0;
    in_ch.pixel_row  = '0;
    in_ch.depth_code = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    edge_val  = '{12'd0, 12'd4095};
    depth_set = '{24'd0, 24'h80_0000, DEPTH_MAX - 24'd17, DEPTH_MAX - 24'd16,
                  DEPTH_MAX - 24'd1, DEPTH_MAX};
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: registers still at reset, so w is zero for geometry pixels.
    send_pixel(12'd0, 12'd0, 24'd0);
    send_pixel(12'd4095, 12'd4095, DEPTH_MAX);
    drain();

    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      load_matrix(phase);
      quiet = (phase == 3);   // one long stretch without idling on either side
      if (phase == 1 || phase == 2)
        foreach (edge_val[i])
          foreach (edge_val[j])
            foreach (depth_set[d])
              if (d % 2 == (i ^ j) || phase == 1)
                send_pixel(edge_val[i], edge_val[j], depth_set[d]);
      for (int n = 0; n < PHASE_PIX; n++) begin
        // Hold off once mid-phase until the block has returned every point.
        if (phase == 4 && n == PHASE_PIX / 2) begin
          in_ch.valid = 1'b0;
          while (sb.owed_points.size() != 0) @(negedge clk);
        end
        send_pixel($urandom(), $urandom(), pick_depth());
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.owed_points.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/dpu_pkg.sv
rtl/dpu_in_if.sv
rtl/dpu_out_if.sv
rtl/dpu_cfg_if.sv
rtl/dpu_matrix.sv
rtl/dpu_divider.sv
rtl/depth_pixel_unproject.sv
tb/depth_pixel_unproject_tb.sv
